### rtl/core/mvpt_pkg.sv
`timescale 1ns / 1ps
package mvpt_pkg;
	localparam logic [2:0] CMD_GOTO    = 3'd0;
	localparam logic [2:0] CMD_OPEN    = 3'd1;
	localparam logic [2:0] CMD_CLOSE   = 3'd2;
	localparam logic [2:0] CMD_STOP    = 3'd3;
	localparam logic [2:0] CMD_TICK    = 3'd4;
	localparam logic [2:0] CMD_ENDSTOP = 3'd5;
	localparam logic [2:0] CMD_RESTORE = 3'd6;
	localparam logic [2:0] CMD_UNUSED  = 3'd7;

	localparam logic [1:0] M_IDLE  = 2'd0;
	localparam logic [1:0] M_OPEN  = 2'd1;
	localparam logic [1:0] M_CLOSE = 2'd2;

	localparam logic [2:0] R_NONE    = 3'd0;
	localparam logic [2:0] R_CMD     = 3'd1;
	localparam logic [2:0] R_TARGET  = 3'd2;
	localparam logic [2:0] R_TIMEOUT = 3'd3;
	localparam logic [2:0] R_ENDSTOP = 3'd4;

	localparam logic [1:0] REG_OPEN  = 2'd0;
	localparam logic [1:0] REG_CLOSE = 2'd1;
	localparam logic [1:0] REG_MAX   = 2'd2;
	localparam logic [1:0] REG_BLANK = 2'd3;

	localparam int DIV_W = 24;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture the item and begin
		logic div_start;  // start the step division
		logic apply;      // run the command update
	} mvpt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;   // item is a tick while moving
		logic div_done;
	} mvpt_sts_t;
endpackage

### rtl/core/mvpt_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module mvpt_div #(
	parameter int NUM_W = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [NUM_W-1:0]         num,
	input  logic [mvpt_pkg::DIV_W-1:0] den,
	output logic [NUM_W-1:0]         quo,
	output logic                     done
);
	localparam int CW = $clog2(NUM_W + 1);
	logic [NUM_W-1:0]            q_q;
	logic [mvpt_pkg::DIV_W:0]    r_q;
	logic [mvpt_pkg::DIV_W-1:0]  d_q;
	logic [CW-1:0]               cnt_q;
	logic                        busy_q;
	logic [mvpt_pkg::DIV_W+1:0]  trial;

	assign trial = {r_q, q_q[NUM_W-1]} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!trial[mvpt_pkg::DIV_W+1]) begin
				r_q <= trial[mvpt_pkg::DIV_W:0];
				q_q <= {q_q[NUM_W-2:0], 1'b1};
			end else begin
				r_q <= {r_q[mvpt_pkg::DIV_W-1:0], q_q[NUM_W-1]};
				q_q <= {q_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
endmodule

### rtl/core/mvpt_ctrl.sv
`timescale 1ns / 1ps
module mvpt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  mvpt_pkg::mvpt_sts_t sts,
	output mvpt_pkg::mvpt_cmd_t cmd
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DECODE = 2'd1;
	localparam logic [1:0] S_DIV = 2'd2;
	localparam logic [1:0] S_APPLY = 2'd3;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.div_start = (state_q == S_DECODE) && sts.need_div;
		cmd.apply     = (state_q == S_APPLY) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.apply)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_DECODE;
				S_DECODE: state_q <= sts.need_div ? S_DIV : S_APPLY;
				S_DIV:    if (sts.div_done) state_q <= S_APPLY;
				S_APPLY:  if (out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/core/mvpt_dp.sv
`timescale 1ns / 1ps
module mvpt_dp #(
	parameter int DEFAULT_BLANK_MS = 500,
	parameter int EPS_Q16 = 131,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mvpt_pkg::mvpt_cmd_t  cmd,
	output mvpt_pkg::mvpt_sts_t  sts,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_data,
	input  logic [2:0]           cmd_in,
	input  logic [31:0]          now_ms,
	input  logic [FRAC_BITS:0]   position_arg,
	input  logic [FRAC_BITS:0]   dead_band,
	output logic                 acted,
	output logic [1:0]           drive,
	output logic [FRAC_BITS:0]   position_est,
	output logic                 position_valid,
	output logic                 reference_run,
	output logic [2:0]           stop_reason,
	output logic [31:0]          move_duration_ms
);
	localparam int PW = FRAC_BITS + 1;
	localparam int NW = 32 + FRAC_BITS;
	localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;
	localparam logic [PW-1:0] EPS = PW'(EPS_Q16);

	logic [23:0] open_q, close_q, max_q;
	logic [15:0] blank_q;
	logic [2:0]  c_q;
	logic [31:0] now_q;
	logic [PW-1:0] arg_q, mind_q;

	logic [1:0]    motion_q;
	logic [PW-1:0] pos_q, tgt_q, pend_q;
	logic          known_q, pendf_q, ref_q;
	logic [31:0]   start_q, last_q, dur_q;
	logic [2:0]    reason_q;

	logic [NW-1:0] quo;
	logic          div_done;
	logic [31:0]   dt;
	logic [23:0]   travel;

	assign dt = now_q - last_q;
	always_comb begin
		travel = (motion_q == mvpt_pkg::M_OPEN) ? open_q : close_q;
		if (travel == '0) travel = 24'd1;
	end

	mvpt_div #(.NUM_W(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num({dt, {FRAC_BITS{1'b0}}}), .den(travel), .quo(quo), .done(div_done)
	);

	assign sts.need_div = (c_q == mvpt_pkg::CMD_TICK) && (motion_q != mvpt_pkg::M_IDLE);
	assign sts.div_done = div_done;

	function automatic logic [PW-1:0] adiff(input logic [PW-1:0] a, input logic [PW-1:0] b);
		adiff = (a > b) ? a - b : b - a;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 24'd180000;
			close_q <= 24'd180000;
			max_q   <= '0;
			blank_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mvpt_pkg::REG_OPEN:  open_q  <= cfg_data;
				mvpt_pkg::REG_CLOSE: close_q <= cfg_data;
				mvpt_pkg::REG_MAX:   max_q   <= cfg_data;
				mvpt_pkg::REG_BLANK: blank_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_q    <= cmd_in;
			now_q  <= now_ms;
			arg_q  <= position_arg;
			mind_q <= dead_band;
		end
	end

	// next-state logic for the whole command
	logic [1:0]    n_motion;
	logic [PW-1:0] n_pos, n_tgt, n_pend;
	logic          n_known, n_pendf, n_ref, n_acted;
	logic [31:0]   n_start, n_last, n_dur;
	logic [2:0]    n_reason;
	logic [PW-1:0] argc, st;
	logic [PW:0]   sum;
	logic [31:0]   el, blank;
	logic          fin, was_ref, resumed, res_chk;

	always_comb begin
		n_motion = motion_q; n_pos = pos_q; n_tgt = tgt_q; n_pend = pend_q;
		n_known = known_q; n_pendf = pendf_q; n_ref = ref_q; n_acted = 1'b0;
		n_start = start_q; n_last = last_q; n_dur = dur_q; n_reason = reason_q;
		argc = (arg_q > ONE) ? ONE : arg_q;
		st = (quo > NW'(ONE)) ? ONE : quo[PW-1:0];
		sum = {1'b0, pos_q} + {1'b0, st};
		el = now_q - start_q;
		blank = (blank_q != '0) ? {16'd0, blank_q} : 32'(DEFAULT_BLANK_MS);
		fin = 1'b0; was_ref = ref_q; resumed = 1'b0; res_chk = 1'b0;
		case (c_q)
			mvpt_pkg::CMD_GOTO: begin
				if (!known_q) begin
					n_pend = argc; n_pendf = 1'b1; n_ref = 1'b1; n_pos = ONE;
					n_tgt = '0; n_motion = mvpt_pkg::M_CLOSE;
					n_start = now_q; n_last = now_q; n_acted = 1'b1;
				end else if (!((motion_q != mvpt_pkg::M_IDLE) && adiff(tgt_q, argc) <= EPS)
						&& !((motion_q == mvpt_pkg::M_IDLE) && adiff(pos_q, argc) <= mind_q)) begin
					n_ref = 1'b0; n_pendf = 1'b0; n_tgt = argc;
					n_motion = (argc > pos_q) ? mvpt_pkg::M_OPEN : mvpt_pkg::M_CLOSE;
					n_start = now_q; n_last = now_q; n_acted = 1'b1;
				end
			end
			mvpt_pkg::CMD_OPEN, mvpt_pkg::CMD_CLOSE: begin
				n_ref = 1'b0; n_pendf = 1'b0;
				n_tgt = (c_q == mvpt_pkg::CMD_OPEN) ? ONE : '0;
				n_motion = (c_q == mvpt_pkg::CMD_OPEN) ? mvpt_pkg::M_OPEN : mvpt_pkg::M_CLOSE;
				n_start = now_q; n_last = now_q; n_acted = 1'b1;
			end
			mvpt_pkg::CMD_STOP: begin
				n_ref = 1'b0; n_pendf = 1'b0;
				if (motion_q != mvpt_pkg::M_IDLE) n_dur = el;
				n_motion = mvpt_pkg::M_IDLE; n_reason = mvpt_pkg::R_CMD;
			end
			mvpt_pkg::CMD_TICK: begin
				if (motion_q != mvpt_pkg::M_IDLE) begin
					n_last = now_q;
					if (motion_q == mvpt_pkg::M_OPEN) begin
						n_pos = (sum > {1'b0, ONE}) ? ONE : sum[PW-1:0];
						if ({1'b0, n_pos} + {1'b0, EPS} >= {1'b0, tgt_q}) begin
							n_pos = tgt_q; fin = 1'b1;
						end
					end else begin
						n_pos = (quo >= NW'(pos_q)) ? '0 : pos_q - quo[PW-1:0];
						if ({1'b0, n_pos} <= {1'b0, tgt_q} + {1'b0, EPS}) begin
							n_pos = tgt_q; fin = 1'b1; res_chk = 1'b1;
						end
					end
					if (fin) begin
						n_dur = el; n_motion = mvpt_pkg::M_IDLE;
						n_reason = mvpt_pkg::R_TARGET; n_acted = 1'b1;
					end else if (max_q != '0 && el >= {8'd0, max_q}) begin
						if (tgt_q <= EPS) begin
							n_pos = '0; n_known = 1'b1;
						end else if ({1'b0, tgt_q} + {1'b0, EPS} >= {1'b0, ONE}) begin
							n_pos = ONE; n_known = 1'b1;
						end
						n_dur = el; n_motion = mvpt_pkg::M_IDLE;
						n_reason = mvpt_pkg::R_TIMEOUT; n_acted = 1'b1;
						res_chk = was_ref;
					end
				end
			end
			mvpt_pkg::CMD_ENDSTOP: begin
				if (motion_q != mvpt_pkg::M_IDLE && el >= blank) begin
					n_pos = (motion_q == mvpt_pkg::M_OPEN) ? ONE : '0;
					n_known = 1'b1; n_dur = el; n_motion = mvpt_pkg::M_IDLE;
					n_reason = mvpt_pkg::R_ENDSTOP; n_acted = 1'b1;
					if (was_ref) begin
						n_ref = 1'b0; res_chk = 1'b1;
					end
				end
			end
			mvpt_pkg::CMD_RESTORE: begin
				n_pos = argc; n_known = 1'b1;
			end
			default: ;
		endcase
		// resume the pending target after a run ends
		if (res_chk && pendf_q) begin
			n_pendf = 1'b0; n_ref = 1'b0;
			if (adiff(n_pos, pend_q) > EPS) begin
				resumed = 1'b1; n_tgt = pend_q;
				n_motion = (pend_q > n_pos) ? mvpt_pkg::M_OPEN : mvpt_pkg::M_CLOSE;
				n_start = now_q; n_last = now_q;
			end
		end
		if (c_q == mvpt_pkg::CMD_TICK && fin && motion_q == mvpt_pkg::M_CLOSE
				&& (was_ref || resumed))
			n_known = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_q <= mvpt_pkg::M_IDLE;
			pos_q <= '0; tgt_q <= '0; pend_q <= '0;
			known_q <= 1'b0; pendf_q <= 1'b0; ref_q <= 1'b0;
			start_q <= '0; last_q <= '0; dur_q <= '0;
			reason_q <= mvpt_pkg::R_NONE;
			acted <= 1'b0;
		end else if (cmd.apply) begin
			motion_q <= n_motion;
			pos_q <= n_pos; tgt_q <= n_tgt; pend_q <= n_pend;
			known_q <= n_known; pendf_q <= n_pendf; ref_q <= n_ref;
			start_q <= n_start; last_q <= n_last; dur_q <= n_dur;
			reason_q <= n_reason;
			acted <= n_acted;
		end
	end

	assign drive = motion_q;
	assign position_est = pos_q;
	assign position_valid = known_q;
	assign reference_run = ref_q;
	assign stop_reason = reason_q;
	assign move_duration_ms = dur_q;
endmodule

### rtl/core/motor_valve_position_tracker_top.sv
`timescale 1ns / 1ps
// Channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | cmd, now_ms, position_arg, dead_band
// out     | output    | out_valid / out_stall| acted, drive, position_est, position_valid,
//         |           |                      | reference_run, stop_reason, move_duration_ms
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One item at a time. A tick while moving passes through load, decode, the
// bit-serial step divider and update; every other command skips the divider.
// Reset (arst_n low) clears motion, position, flags and registers to their defaults.
// The input stalls while an item is in work; a result held by out_stall holds
// the next item in its update step.
module motor_valve_position_tracker_top #(
	parameter int DEFAULT_BLANK_MS = 500,
	parameter int EPS_Q16 = 131,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           cmd,
	input  logic [31:0]          now_ms,
	input  logic [FRAC_BITS:0]   position_arg,
	input  logic [FRAC_BITS:0]   dead_band,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 acted,
	output logic [1:0]           drive,
	output logic [FRAC_BITS:0]   position_est,
	output logic                 position_valid,
	output logic                 reference_run,
	output logic [2:0]           stop_reason,
	output logic [31:0]          move_duration_ms
);
	mvpt_pkg::mvpt_cmd_t c;
	mvpt_pkg::mvpt_sts_t s;

	// sequence load, divide and update
	mvpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(s), .cmd(c)
	);

	// hold state, registers and the step divider
	mvpt_dp #(
		.DEFAULT_BLANK_MS(DEFAULT_BLANK_MS), .EPS_Q16(EPS_Q16), .FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(c), .sts(s),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd_in(cmd), .now_ms(now_ms), .position_arg(position_arg), .dead_band(dead_band),
		.acted(acted), .drive(drive), .position_est(position_est),
		.position_valid(position_valid), .reference_run(reference_run),
		.stop_reason(stop_reason), .move_duration_ms(move_duration_ms)
	);
endmodule

### rtl/core/mvpt_checker.sv
`timescale 1ns / 1ps
module mvpt_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [1:0]           drive,
	input logic [FRAC_BITS:0]   position_est,
	input logic                 reference_run
);
	localparam int PW = FRAC_BITS + 1;
	localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid) else $error("item dropped");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_drive: assert property (@(posedge clk) disable iff (!arst_n)
		drive <= mvpt_pkg::M_CLOSE) else $error("bad drive");
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		position_est <= ONE) else $error("position out of range");
	a_ref: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reference_run |-> drive == mvpt_pkg::M_CLOSE)
		else $error("reference run not closing");
endmodule

bind motor_valve_position_tracker_top mvpt_checker #(.FRAC_BITS(FRAC_BITS)) u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .drive(drive),
	.position_est(position_est), .reference_run(reference_run)
);
